@@ rtl/pcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsc_pkg
// shared widths, constants and sideband type of the pixel color converter
// ----------------------------------------------------------------------------
package pcsc_pkg;

  localparam int PIX_W      = 8;
  localparam int QUOT_W     = 8;   // every quotient fits in one byte
  localparam int SAT_NUM_W  = 16;  // 255*d or the gray weighted sum
  localparam int SAT_DEN_W  = 8;   // v or the gray divisor
  localparam int HUE_NUM_W  = 17;  // up to 360*255
  localparam int HUE_DEN_W  = 9;   // 2*d
  localparam int GRAY_SUM_W = 15;  // up to 100*255

  localparam logic [SAT_DEN_W-1:0] GRAY_DIV  = 8'd100;
  localparam logic                 MODE_GRAY = 1'b0;
  localparam logic                 MODE_HSV  = 1'b1;

  // control and pass-through data that travels beside the dividers
  typedef struct packed {
    logic             valid;
    logic             mode;
    logic [PIX_W-1:0] value;
  } pcsc_side_t;

endpackage

@@ rtl/pcsc_div.sv @@
// ----------------------------------------------------------------------------
// pcsc_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module pcsc_div
  import pcsc_pkg::*;
#(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 8,
  parameter int Q_W    = 8
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o
);

  localparam int CW = NUM_W + DEN_W;

  // numerator must stay below den << Q_W, so the top quotient bit comes first
  logic [NUM_W-1:0] rem_r  [Q_W-1];
  logic [DEN_W-1:0] den_r  [Q_W-1];
  logic [Q_W-1:0]   quot_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int SH = Q_W - 1 - i;

    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quot_in;
    logic [CW-1:0]    rem_ext;
    logic [CW-1:0]    trial;
    logic             fits;
    logic [Q_W-1:0]   quot_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quot_in = quot_r[i-1];
    end

    assign rem_ext  = CW'(rem_in);
    assign trial    = CW'(den_in) << SH;
    assign fits     = (rem_ext >= trial);
    assign quot_nxt = quot_in | (Q_W'(fits) << SH);

    always_ff @(posedge clk) begin
      quot_r[i] <= quot_nxt;
    end

    if (i < Q_W - 1) begin : g_carry
      logic [NUM_W-1:0] rem_nxt;

      assign rem_nxt = fits ? NUM_W'(rem_ext - trial) : rem_in;

      always_ff @(posedge clk) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
      end
    end
  end

  assign quot_o = quot_r[Q_W-1];

endmodule

@@ rtl/pcsc_front.sv @@
// ----------------------------------------------------------------------------
// pcsc_front
// two stages: max/min and gray sum, then divider numerators and divisors
// ----------------------------------------------------------------------------
module pcsc_front
  import pcsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic                 mode,
  input  logic [PIX_W-1:0]     blue,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     red,
  output pcsc_side_t           side_o,
  output logic [SAT_NUM_W-1:0] sat_num_o,
  output logic [SAT_DEN_W-1:0] sat_den_o,
  output logic [HUE_NUM_W-1:0] hue_num_o,
  output logic [HUE_DEN_W-1:0] hue_den_o
);

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_t;

  // stage 1
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_mode_r;
  logic [PIX_W-1:0]      s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0]      s1_d_r, s1_d_nxt;
  sect_t                 s1_sect_r, s1_sect_nxt;
  logic signed [PIX_W:0] s1_diff_r, s1_diff_nxt;
  logic [GRAY_SUM_W-1:0] s1_gray_r, s1_gray_nxt;

  logic [PIX_W-1:0]      mx_bg, mn_bg, mn_all;

  assign s1_valid_nxt = take;

  always_comb begin
    mx_bg       = (blue > green) ? blue : green;
    s1_v_nxt    = (mx_bg > red) ? mx_bg : red;
    mn_bg       = (blue < green) ? blue : green;
    mn_all      = (mn_bg < red) ? mn_bg : red;
    s1_d_nxt    = s1_v_nxt - mn_all;
    s1_gray_nxt = GRAY_SUM_W'(blue) * GRAY_SUM_W'(11) + GRAY_SUM_W'(green) * GRAY_SUM_W'(59)
                + GRAY_SUM_W'(red) * GRAY_SUM_W'(30);
    // ties go to red, then green
    if (s1_v_nxt == red) begin
      s1_sect_nxt = SECT_RED;
      s1_diff_nxt = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (s1_v_nxt == green) begin
      s1_sect_nxt = SECT_GREEN;
      s1_diff_nxt = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      s1_sect_nxt = SECT_BLUE;
      s1_diff_nxt = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= mode;
    s1_v_r    <= s1_v_nxt;
    s1_d_r    <= s1_d_nxt;
    s1_sect_r <= s1_sect_nxt;
    s1_diff_r <= s1_diff_nxt;
    s1_gray_r <= s1_gray_nxt;
  end

  // stage 2
  pcsc_side_t           s2_side_r, s2_side_nxt;
  logic [SAT_NUM_W-1:0] s2_sat_num_r, s2_sat_num_nxt;
  logic [SAT_DEN_W-1:0] s2_sat_den_r, s2_sat_den_nxt;
  logic [HUE_NUM_W-1:0] s2_hue_num_r, s2_hue_num_nxt;
  logic [HUE_DEN_W-1:0] s2_hue_den_r, s2_hue_den_nxt;

  logic signed [HUE_NUM_W:0] diff_ext, diff60, off_d, full_d, hue_base, hue_wrap;

  always_comb begin
    s2_side_nxt.valid = s1_valid_r;
    s2_side_nxt.mode  = s1_mode_r;
    s2_side_nxt.value = s1_v_r;

    if (s1_mode_r == MODE_HSV) begin
      s2_sat_num_nxt = {s1_d_r, 8'd0} - SAT_NUM_W'(s1_d_r);
      // black pixel: d is zero too, so a divisor of one gives zero
      s2_sat_den_nxt = (s1_v_r == '0) ? SAT_DEN_W'(1) : s1_v_r;
    end else begin
      s2_sat_num_nxt = SAT_NUM_W'(s1_gray_r);
      s2_sat_den_nxt = GRAY_DIV;
    end

    diff_ext = (HUE_NUM_W + 1)'(s1_diff_r);
    diff60   = diff_ext * $signed((HUE_NUM_W + 1)'(60));
    full_d   = $signed((HUE_NUM_W + 1)'(s1_d_r) * (HUE_NUM_W + 1)'(360));
    case (s1_sect_r)
      SECT_RED:   off_d = '0;
      SECT_GREEN: off_d = $signed((HUE_NUM_W + 1)'(s1_d_r) * (HUE_NUM_W + 1)'(120));
      SECT_BLUE:  off_d = $signed((HUE_NUM_W + 1)'(s1_d_r) * (HUE_NUM_W + 1)'(240));
      default:    off_d = '0;
    endcase
    hue_base = off_d + diff60;
    hue_wrap = hue_base + full_d;
    // gray pixel: diff is zero, numerator zero over divisor one
    s2_hue_num_nxt = hue_base[HUE_NUM_W] ? hue_wrap[HUE_NUM_W-1:0]
                                         : hue_base[HUE_NUM_W-1:0];
    s2_hue_den_nxt = (s1_d_r == '0) ? HUE_DEN_W'(1) : {s1_d_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.valid <= 1'b0;
    end else begin
      s2_side_r.valid <= s2_side_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r.mode  <= s2_side_nxt.mode;
    s2_side_r.value <= s2_side_nxt.value;
    s2_sat_num_r    <= s2_sat_num_nxt;
    s2_sat_den_r    <= s2_sat_den_nxt;
    s2_hue_num_r    <= s2_hue_num_nxt;
    s2_hue_den_r    <= s2_hue_den_nxt;
  end

  assign side_o    = s2_side_r;
  assign sat_num_o = s2_sat_num_r;
  assign sat_den_o = s2_sat_den_r;
  assign hue_num_o = s2_hue_num_r;
  assign hue_den_o = s2_hue_den_r;

endmodule

@@ rtl/pixel_color_space_convert.sv @@
// ----------------------------------------------------------------------------
// pixel_color_space_convert
// per-pixel BGR to grayscale or HSV (value, saturation, half hue) converter
// ----------------------------------------------------------------------------
//  channel  ports                                      handshake
//  input    in_blue, in_green, in_red                  start, busy (busy stays low)
//  result   out_value_or_gray, out_saturation,         out_valid, one cycle strobe
//           out_hue_half
//  config   cfg_wdata (mode: 0 gray, 1 HSV)            cfg_we
//
//  one item per clock; each result reaches the ports through two front stages
//  (the first loaded at the edge that takes its item), eight divider stages
//  and one output register
//  the two divider lanes settle one quotient bit per stage and set the latency
//  reset clears the valid bits and the mode register (gray)
//  the receiver cannot stall, so nothing in the pipe ever holds
// ----------------------------------------------------------------------------
module pixel_color_space_convert
  import pcsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] in_blue,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_red,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_value_or_gray,
  output logic [PIX_W-1:0] out_saturation,
  output logic [PIX_W-1:0] out_hue_half,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  logic mode_r, mode_nxt;

  assign mode_nxt = cfg_we ? cfg_wdata : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GRAY;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign busy = 1'b0;

  pcsc_side_t           front_side;
  logic [SAT_NUM_W-1:0] sat_num;
  logic [SAT_DEN_W-1:0] sat_den;
  logic [HUE_NUM_W-1:0] hue_num;
  logic [HUE_DEN_W-1:0] hue_den;
  logic [QUOT_W-1:0]    sat_quot;
  logic [QUOT_W-1:0]    hue_quot;

  pcsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .mode      (mode_r),
    .blue      (in_blue),
    .green     (in_green),
    .red       (in_red),
    .side_o    (front_side),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den)
  );

  // gray divide by 100 in gray mode, saturation in HSV mode
  pcsc_div #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (SAT_DEN_W),
    .Q_W   (QUOT_W)
  ) u_sat_div (
    .clk    (clk),
    .num_i  (sat_num),
    .den_i  (sat_den),
    .quot_o (sat_quot)
  );

  pcsc_div #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (HUE_DEN_W),
    .Q_W   (QUOT_W)
  ) u_hue_div (
    .clk    (clk),
    .num_i  (hue_num),
    .den_i  (hue_den),
    .quot_o (hue_quot)
  );

  // sideband follows the divider stages
  pcsc_side_t side_r [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_side
    pcsc_side_t side_nxt;

    if (i == 0) begin : g_first
      assign side_nxt = front_side;
    end else begin : g_next
      assign side_nxt = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i].valid <= side_nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i].mode  <= side_nxt.mode;
      side_r[i].value <= side_nxt.value;
    end
  end

  pcsc_side_t       tail;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_vg_r, out_vg_nxt;
  logic [PIX_W-1:0] out_sat_r, out_sat_nxt;
  logic [PIX_W-1:0] out_hue_r, out_hue_nxt;

  assign tail = side_r[QUOT_W-1];

  always_comb begin
    out_valid_nxt = tail.valid;
    if (tail.mode == MODE_HSV) begin
      out_vg_nxt  = tail.value;
      out_sat_nxt = sat_quot;
      out_hue_nxt = hue_quot;
    end else begin
      out_vg_nxt  = sat_quot;
      out_sat_nxt = '0;
      out_hue_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_vg_r  <= out_vg_nxt;
    out_sat_r <= out_sat_nxt;
    out_hue_r <= out_hue_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_value_or_gray = out_vg_r;
  assign out_saturation    = out_sat_r;
  assign out_hue_half      = out_hue_r;

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_half <= 8'd179)
    else $error("hue above 179");

  a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(tail.mode) && out_value_or_gray == 8'd0
      |-> out_saturation == 8'd0 && out_hue_half == 8'd0)
    else $error("black pixel with nonzero saturation or hue");

  a_hue_needs_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(tail.mode) && out_hue_half != 8'd0 |-> out_saturation != 8'd0)
    else $error("hue set on a pixel without saturation");
`endif

endmodule

@@ sim/pcsc_conversion_checker.sv @@
// ----------------------------------------------------------------------------
// pcsc_conversion_checker
// watches the pixel and result channels of the color converter, predicts each
// converted pixel from the accepted item and the mode, and compares in order
// ----------------------------------------------------------------------------
module pcsc_conversion_checker
  import pcsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [PIX_W-1:0] in_blue,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_red,
  input  logic             out_valid,
  input  logic [PIX_W-1:0] out_value_or_gray,
  input  logic [PIX_W-1:0] out_saturation,
  input  logic [PIX_W-1:0] out_hue_half,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [PIX_W-1:0] value_or_gray;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] hue_half;
  } conv_pixel_t;

  logic        conv_mode;
  conv_pixel_t expected_pixels[$];

  function automatic conv_pixel_t convert_pixel(logic mode_sel, logic [PIX_W-1:0] b,
                                                logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
    int          bi, gi, ri, vmax, vmin, d, num;
    conv_pixel_t px;
    px = '0;
    bi = int'(b);
    gi = int'(g);
    ri = int'(r);
    if (mode_sel == MODE_GRAY) begin
      px.value_or_gray = PIX_W'((11 * bi + 59 * gi + 30 * ri) / 100);
      return px;
    end
    vmax = (bi > gi) ? bi : gi;
    vmax = (vmax > ri) ? vmax : ri;
    vmin = (bi < gi) ? bi : gi;
    vmin = (vmin < ri) ? vmin : ri;
    d    = vmax - vmin;
    px.value_or_gray = PIX_W'(vmax);
    if (vmax != 0) px.saturation = PIX_W'((255 * d) / vmax);
    // gray pixels keep hue at zero; ties resolve red, then green, then blue
    if (d != 0) begin
      if (vmax == ri)      num = 60 * (gi - bi);
      else if (vmax == gi) num = 120 * d + 60 * (bi - ri);
      else                 num = 240 * d + 60 * (ri - gi);
      if (num < 0) num = num + 360 * d;
      px.hue_half = PIX_W'(num / (2 * d));
    end
    return px;
  endfunction

  task automatic check_field(string field, logic [PIX_W-1:0] exp_v, logic [PIX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fail_count = fail_count + 1;
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    conv_mode     = MODE_GRAY;
  end

  always @(posedge clk) begin
    conv_pixel_t exp_px;
    if (!rst_n) begin
      conv_mode <= MODE_GRAY;
      expected_pixels.delete();
      pending_count <= 0;
    end else begin
      if (cfg_we) conv_mode <= cfg_wdata;
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                   out_value_or_gray, out_saturation, out_hue_half);
          fail_count = fail_count + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          check_field("value_or_gray", exp_px.value_or_gray, out_value_or_gray);
          check_field("saturation", exp_px.saturation, out_saturation);
          check_field("hue_half", exp_px.hue_half, out_hue_half);
        end
      end
      if (start && !busy)
        expected_pixels.push_back(convert_pixel(conv_mode, in_blue, in_green, in_red));
      pending_count <= expected_pixels.size();
    end
  end

endmodule

@@ sim/pixel_color_space_convert_test.sv @@
// ----------------------------------------------------------------------------
// pixel_color_space_convert_test
// drives directed and random pixels through the converter in both modes, with
// bursty input and mode changes between phases; the checker gives the verdict
// ----------------------------------------------------------------------------
module pixel_color_space_convert_test;
  import pcsc_pkg::*;

  localparam int SETTLE_CYCLES = 14;   // pipe latency plus margin
  localparam int STALL_LIMIT   = 2000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_blue;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_red;
  logic             out_valid;
  logic [PIX_W-1:0] out_value_or_gray;
  logic [PIX_W-1:0] out_saturation;
  logic [PIX_W-1:0] out_hue_half;
  logic             cfg_we;
  logic             cfg_wdata;
  int               fail_count;
  int               pending_count;
  int               stall_cycles;

  pixel_color_space_convert u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .out_valid         (out_valid),
    .out_value_or_gray (out_value_or_gray),
    .out_saturation    (out_saturation),
    .out_hue_half      (out_hue_half),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  pcsc_conversion_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .out_valid         (out_valid),
    .out_value_or_gray (out_value_or_gray),
    .out_saturation    (out_saturation),
    .out_hue_half      (out_hue_half),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // any accepted item or result resets the stall count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
    @(negedge clk);
    start    <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (busy);
  endtask

  // start low, data wiggling so ignored values are seen too
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start    <= 1'b0;
      in_blue  <= PIX_W'($urandom);
      in_green <= PIX_W'($urandom);
      in_red   <= PIX_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int count);
    int               sent;
    int               burst;
    logic [PIX_W-1:0] b, g, r, v;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        b = PIX_W'($urandom);
        g = PIX_W'($urandom);
        r = PIX_W'($urandom);
        v = PIX_W'($urandom);
        case ($urandom_range(0, 9))
          0: begin g = b; r = b; end
          1: begin r = v; g = v; b = PIX_W'($urandom_range(0, v)); end
          2: begin g = v; b = v; r = PIX_W'($urandom_range(0, v)); end
          3: begin r = v; b = v; g = PIX_W'($urandom_range(0, v)); end
          4: begin
            b = {PIX_W{v[0]}};
            g = {PIX_W{v[1]}};
            r = {PIX_W{v[2]}};
          end
          default: ;
        endcase
        send_pixel(b, g, r);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_blue      = '0;
    in_green     = '0;
    in_red       = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = MODE_GRAY;
    stall_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // gray mode straight out of reset
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd2, 8'd3);
    wait_for_results();

    set_mode(MODE_HSV);
    send_pixel(8'd0, 8'd0, 8'd0);        // black
    send_pixel(8'd128, 8'd128, 8'd128);  // gray, no hue
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255);      // pure red
    send_pixel(8'd0, 8'd255, 8'd0);      // pure green
    send_pixel(8'd255, 8'd0, 8'd0);      // pure blue
    send_pixel(8'd100, 8'd0, 8'd255);    // red max, hue wraps
    send_pixel(8'd1, 8'd0, 8'd255);      // hue just below full circle
    send_pixel(8'd10, 8'd200, 8'd200);   // red and green tie
    send_pixel(8'd200, 8'd200, 8'd10);   // green and blue tie
    send_pixel(8'd200, 8'd50, 8'd200);   // red and blue tie
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd0);
    wait_for_results();

    set_mode(MODE_GRAY);
    run_random(150);
    wait_for_results();
    set_mode(MODE_HSV);
    run_random(200);
    wait_for_results();
    set_mode(MODE_GRAY);
    run_random(150);
    wait_for_results();
    set_mode(MODE_HSV);
    run_random(200);
    wait_for_results();
    set_mode(MODE_HSV);
    run_random(180);
    wait_for_results();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ pixel_color_space_convert.f @@
rtl/pcsc_pkg.sv
rtl/pcsc_div.sv
rtl/pcsc_front.sv
rtl/pixel_color_space_convert.sv
sim/pcsc_conversion_checker.sv
sim/pixel_color_space_convert_test.sv
